[design/irpw_pkg.sv]
// ----------------------------------------------------------------------------
// irpw_pkg
// shared types and constants of the pulse-width ir frame sender
// ----------------------------------------------------------------------------
`default_nettype none

package irpw_pkg;

   // default frame length limit
   localparam int MAX_BITS_DEF = 32;

   // duration registers, all in ticks
   localparam int DUR_W = 16;
   localparam logic [DUR_W-1:0] START_MARK_RST = 16'd2400;
   localparam logic [DUR_W-1:0] ONE_MARK_RST   = 16'd1200;
   localparam logic [DUR_W-1:0] ZERO_MARK_RST  = 16'd600;
   localparam logic [DUR_W-1:0] SPACE_RST      = 16'd600;

   // payload widths
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 6;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_START_MARK = 2'd0,
      REG_ONE_MARK   = 2'd1,
      REG_ZERO_MARK  = 2'd2,
      REG_SPACE      = 2'd3
   } reg_index_type;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_LOAD = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_MARK  = 3'b010,
      PH_SPACE = 3'b100
   } phase_type;

   // durations handed to the frame engine
   typedef struct packed {
      logic [DUR_W-1:0] start_mark;
      logic [DUR_W-1:0] one_mark;
      logic [DUR_W-1:0] zero_mark;
      logic [DUR_W-1:0] space;
   } timing_type;

   // one result word
   typedef struct packed {
      logic ir_on;
      logic busy_res;
      logic load_rejected;
      logic frame_done;
   } result_type;

   // a zero duration lasts one tick
   function automatic logic [DUR_W-1:0] dur_fix(input logic [DUR_W-1:0] v);
      dur_fix = (v == '0) ? DUR_W'(1) : v;
   endfunction

endpackage

`default_nettype wire

[design/irpw_engine.sv]
// ----------------------------------------------------------------------------
// irpw_engine
// frame state and phase countdown, one word per cycle while accept is high
// ----------------------------------------------------------------------------
`default_nettype none

module irpw_engine #(
   parameter int MAX_BITS = irpw_pkg::MAX_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic                         operation,
   input  wire logic [irpw_pkg::DATA_W-1:0]  frame_data,
   input  wire logic [irpw_pkg::COUNT_W-1:0] bit_count,
   input  wire irpw_pkg::timing_type         timing,
   output irpw_pkg::result_type              result
);
   import irpw_pkg::*;

   localparam int BL_W  = $clog2(MAX_BITS + 1);
   localparam int CMP_W = (BL_W > COUNT_W) ? BL_W : COUNT_W;

   phase_type          phase_ff, phase_in;
   logic [BL_W-1:0]    bits_left_ff, bits_left_in;
   logic [DATA_W-1:0]  shift_word_ff, shift_word_in;
   logic [DUR_W-1:0]   ticks_ff, ticks_in;

   logic [CMP_W-1:0]   cnt_ext;
   logic [BL_W-1:0]    cnt_sat;
   logic [BL_W-1:0]    idx;
   logic [DATA_W-1:0]  shifted;
   logic [DUR_W-1:0]   ticks_dec;

   always_comb begin
      cnt_ext   = CMP_W'(bit_count);
      cnt_sat   = (cnt_ext > CMP_W'(MAX_BITS)) ? BL_W'(MAX_BITS) : BL_W'(cnt_ext);
      idx       = bits_left_ff - BL_W'(1);
      // positions at or above the word width shift out as zero
      shifted   = shift_word_ff >> idx;
      ticks_dec = ticks_ff - DUR_W'(1);

      phase_in      = phase_ff;
      bits_left_in  = bits_left_ff;
      shift_word_in = shift_word_ff;
      ticks_in      = ticks_ff;
      result        = '0;

      if (operation == OP_LOAD) begin
         if (phase_ff != PH_IDLE) begin
            result.load_rejected = 1'b1;
         end else begin
            shift_word_in = frame_data;
            bits_left_in  = cnt_sat;
            phase_in      = PH_MARK;
            ticks_in      = dur_fix(timing.start_mark);
         end
         result.busy_res = (phase_in != PH_IDLE);
         result.ir_on    = (phase_in == PH_MARK);
      end else if (phase_ff != PH_IDLE) begin
         result.busy_res = 1'b1;
         result.ir_on    = (phase_ff == PH_MARK);
         ticks_in        = ticks_dec;
         if (ticks_dec == '0) begin
            priority if (phase_ff == PH_MARK) begin
               phase_in = PH_SPACE;
               ticks_in = dur_fix(timing.space);
            end else if (bits_left_ff != '0) begin
               bits_left_in = idx;
               phase_in     = PH_MARK;
               ticks_in     = shifted[0] ? dur_fix(timing.one_mark)
                                         : dur_fix(timing.zero_mark);
            end else begin
               phase_in          = PH_IDLE;
               result.frame_done = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bits_left_ff  <= '0;
         shift_word_ff <= '0;
         ticks_ff      <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         bits_left_ff  <= bits_left_in;
         shift_word_ff <= shift_word_in;
         ticks_ff      <= ticks_in;
      end
   end

endmodule

`default_nettype wire

[design/ir_pulse_width_frame_sender.sv]
// ----------------------------------------------------------------------------
// ir_pulse_width_frame_sender
// pulse-width infrared frame sender driven by tick and load words
// ----------------------------------------------------------------------------
// usage:
//   req channel: each word is a tick (operation 0) or a frame load
//   (operation 1 with frame_data and bit_count). a load starts a frame of a
//   start mark, then bit_count data marks msb first (long for 1, short for
//   0), each mark followed by one space. a load while busy is rejected.
//   rsp channel: exactly one word per request word, carrying the carrier
//   level, busy flag, reject flag and end-of-frame flag.
//   csr port: four 16-bit duration registers at byte addresses 0, 4, 8, 12
//   (start mark, one mark, zero mark, space); write only while idle.
// timing:
//   each result is registered in the output buffer; throughput is one
//   word per cycle while the skid slot is empty, set by the engine's state update.
// reset:
//   synchronous; durations return to defaults, the frame engine goes idle
//   and both output slots empty.
// backpressure:
//   a two-slot output buffer absorbs one extra word while rsp_stall is
//   high; req_stall rises only once both slots hold words.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_width_frame_sender #(
   parameter int MAX_BITS = irpw_pkg::MAX_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_operation,
   input  wire logic [irpw_pkg::DATA_W-1:0]     req_frame_data,
   input  wire logic [irpw_pkg::COUNT_W-1:0]    req_bit_count,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_ir_on,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_load_rejected,
   output logic                                 rsp_frame_done,
   // configuration port
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [irpw_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [irpw_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [irpw_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import irpw_pkg::*;

   // duration registers
   timing_type    timing_ff;
   reg_index_type csr_index;
   logic          csr_write;

   // output buffer: main slot drives the port, skid slot catches overflow
   result_type    out_ff, out_in;
   result_type    skid_ff, skid_in;
   logic          out_valid_ff, out_valid_in;
   logic          skid_valid_ff, skid_valid_in;

   logic          accept;
   logic          pop;
   result_type    result;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      unique case (csr_index)
         REG_START_MARK: csr_prdata = CSR_DATA_W'(timing_ff.start_mark);
         REG_ONE_MARK:   csr_prdata = CSR_DATA_W'(timing_ff.one_mark);
         REG_ZERO_MARK:  csr_prdata = CSR_DATA_W'(timing_ff.zero_mark);
         REG_SPACE:      csr_prdata = CSR_DATA_W'(timing_ff.space);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.start_mark <= START_MARK_RST;
         timing_ff.one_mark   <= ONE_MARK_RST;
         timing_ff.zero_mark  <= ZERO_MARK_RST;
         timing_ff.space      <= SPACE_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_START_MARK: timing_ff.start_mark <= csr_pwdata[DUR_W-1:0];
            REG_ONE_MARK:   timing_ff.one_mark   <= csr_pwdata[DUR_W-1:0];
            REG_ZERO_MARK:  timing_ff.zero_mark  <= csr_pwdata[DUR_W-1:0];
            REG_SPACE:      timing_ff.space      <= csr_pwdata[DUR_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- engine
   // new words come in as long as the skid slot is free
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~req_stall;
   assign pop       = out_valid_ff & ~rsp_stall;

   irpw_engine #(
      .MAX_BITS (MAX_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .operation  (req_operation),
      .frame_data (req_frame_data),
      .bit_count  (req_bit_count),
      .timing     (timing_ff),
      .result     (result)
   );

   // ---------------------------------------------------------------- output buffer
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;

      if (skid_valid_ff) begin
         // no accept possible here; drain skid into main slot on pop
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload slots need no reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_ir_on         = out_ff.ir_on;
   assign rsp_busy_res      = out_ff.busy_res;
   assign rsp_load_rejected = out_ff.load_rejected;
   assign rsp_frame_done    = out_ff.frame_done;

endmodule

`default_nettype wire

[design/irpw_checker.sv]
// ----------------------------------------------------------------------------
// irpw_checker
// port-level checks of the pulse-width ir frame sender
// ----------------------------------------------------------------------------
`default_nettype none

module irpw_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic                            rsp_ir_on,
   input wire logic                            rsp_busy_res,
   input wire logic                            rsp_load_rejected,
   input wire logic                            rsp_frame_done,
   input wire logic                            csr_psel,
   input wire logic                            csr_penable,
   input wire logic                            csr_pwrite,
   input wire logic [irpw_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [irpw_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input wire logic [irpw_pkg::CSR_DATA_W-1:0] csr_prdata,
   input wire logic                            csr_pready
);

   // end of frame and reject both imply the frame was running
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_done || rsp_load_rejected) |-> rsp_busy_res)
      else $error("done or reject without busy");

   // a word is either an end of frame or a rejected load, never both
   a_done_rej: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_frame_done && rsp_load_rejected))
      else $error("done and reject together");

   // carrier only on while busy
   a_ir_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ir_on |-> rsp_busy_res)
      else $error("carrier on while idle");

   // reset empties the response side
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // a written register reads back its low half-word
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready |=>
         (csr_paddr[3:2] != $past(csr_paddr[3:2])) ||
         (csr_prdata[15:0] == $past(csr_pwdata[15:0])))
      else $error("register readback mismatch");

endmodule

bind ir_pulse_width_frame_sender irpw_checker u_irpw_checker (.*);

`default_nettype wire

[tb/sv/ir_pulse_width_frame_checker.sv]
// ----------------------------------------------------------------------------
// ir_pulse_width_frame_checker
// watches the request, response and csr traffic of the ir frame sender,
// keeps its own copy of the frame engine and compares every response word
// ----------------------------------------------------------------------------
module ir_pulse_width_frame_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_stall,
   input  wire logic                            req_operation,
   input  wire logic [irpw_pkg::DATA_W-1:0]     req_frame_data,
   input  wire logic [irpw_pkg::COUNT_W-1:0]    req_bit_count,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   input  wire logic                            rsp_ir_on,
   input  wire logic                            rsp_busy_res,
   input  wire logic                            rsp_load_rejected,
   input  wire logic                            rsp_frame_done,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic                            csr_pready,
   input  wire logic [irpw_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [irpw_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                                   mismatch_count,
   output int                                   results_pending,
   output logic                                 frame_active
);
   timeunit 1ns;
   timeprecision 1ps;

   import irpw_pkg::*;

   localparam int FRAME_BITS = MAX_BITS_DEF;

   // duration registers as last written
   logic [DUR_W-1:0]   start_mark_len;
   logic [DUR_W-1:0]   one_mark_len;
   logic [DUR_W-1:0]   zero_mark_len;
   logic [DUR_W-1:0]   space_len;

   // frame engine copy
   logic [DATA_W-1:0]  frame_word;
   logic [COUNT_W-1:0] marks_left;
   phase_type          frame_phase;
   logic [DUR_W-1:0]   phase_count;

   result_type         carrier_expect_q[$];
   int                 rsp_seen;

   // a zero register still gives a one-tick phase
   function automatic logic [DUR_W-1:0] ticks_of(input logic [DUR_W-1:0] len);
      return (len == '0) ? DUR_W'(1) : len;
   endfunction

   function automatic result_type advance_frame(input op_type op,
                                                input logic [DATA_W-1:0] word,
                                                input logic [COUNT_W-1:0] count);
      result_type r;
      r = '0;
      if (op == OP_LOAD) begin
         if (frame_phase != PH_IDLE) begin
            r.load_rejected = 1'b1;
         end else begin
            frame_word  = word;
            marks_left  = (count > FRAME_BITS) ? COUNT_W'(FRAME_BITS) : count;
            frame_phase = PH_MARK;
            phase_count = ticks_of(start_mark_len);
         end
         r.busy_res = (frame_phase != PH_IDLE);
         r.ir_on    = (frame_phase == PH_MARK);
      end else if (frame_phase != PH_IDLE) begin
         r.busy_res  = 1'b1;
         r.ir_on     = (frame_phase == PH_MARK);
         phase_count = phase_count - 1'b1;
         if (phase_count == '0) begin
            if (frame_phase == PH_MARK) begin
               frame_phase = PH_SPACE;
               phase_count = ticks_of(space_len);
            end else if (marks_left != '0) begin
               marks_left  = marks_left - 1'b1;
               frame_phase = PH_MARK;
               if ((marks_left < DATA_W) && frame_word[marks_left])
                  phase_count = ticks_of(one_mark_len);
               else
                  phase_count = ticks_of(zero_mark_len);
            end else begin
               frame_phase  = PH_IDLE;
               r.frame_done = 1'b1;
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic check_flag(input string name, input logic got, input logic want);
      if (got !== want)
         report_mismatch($sformatf("response %0d %s is %b, expected %b",
                                   rsp_seen, name, got, want));
   endtask

   always @(posedge clock) begin : watch_channels
      result_type got;
      result_type want;
      if (reset) begin
         start_mark_len = START_MARK_RST;
         one_mark_len   = ONE_MARK_RST;
         zero_mark_len  = ZERO_MARK_RST;
         space_len      = SPACE_RST;
         frame_word     = '0;
         marks_left     = '0;
         frame_phase    = PH_IDLE;
         phase_count    = '0;
         carrier_expect_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[3:2]))
               REG_START_MARK: start_mark_len = csr_pwdata[DUR_W-1:0];
               REG_ONE_MARK:   one_mark_len   = csr_pwdata[DUR_W-1:0];
               REG_ZERO_MARK:  zero_mark_len  = csr_pwdata[DUR_W-1:0];
               REG_SPACE:      space_len      = csr_pwdata[DUR_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            carrier_expect_q.push_back(advance_frame(op_type'(req_operation),
                                                     req_frame_data, req_bit_count));
         if (rsp_valid && !rsp_stall) begin
            got.ir_on         = rsp_ir_on;
            got.busy_res      = rsp_busy_res;
            got.load_rejected = rsp_load_rejected;
            got.frame_done    = rsp_frame_done;
            rsp_seen++;
            if (carrier_expect_q.size() == 0) begin
               report_mismatch($sformatf("response %0d arrived with no word expected",
                                         rsp_seen));
            end else begin
               want = carrier_expect_q.pop_front();
               check_flag("ir_on", got.ir_on, want.ir_on);
               check_flag("busy_res", got.busy_res, want.busy_res);
               check_flag("load_rejected", got.load_rejected, want.load_rejected);
               check_flag("frame_done", got.frame_done, want.frame_done);
            end
         end
      end
      results_pending = carrier_expect_q.size();
      frame_active    = (frame_phase != PH_IDLE);
   end

endmodule

[tb/sv/tb_ir_pulse_width_frame_sender.sv]
// ----------------------------------------------------------------------------
// tb_ir_pulse_width_frame_sender
// stimulus and verdict for the pulse-width ir frame sender: a directed
// opening, random tick and load traffic under changing duration settings and
// idling patterns, then the opening ticks of a frame with every duration at
// its maximum
// ----------------------------------------------------------------------------
module tb_ir_pulse_width_frame_sender;
   timeunit 1ns;
   timeprecision 1ps;

   import irpw_pkg::*;

   localparam int QUIET_LIMIT   = 4000;  // cycles with no word moving
   localparam int SEGMENTS      = 4;     // duration settings per idling mode
   localparam int SEGMENT_WORDS = 85;    // random words per setting
   localparam int SETTLE_CYCLES = 8;     // cycles waited before the verdict
   localparam int MAX_LEN_TICKS = 20;    // ticks sent into the longest frame

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   // request side
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic                  req_operation  = OP_TICK;
   logic [DATA_W-1:0]     req_frame_data = '0;
   logic [COUNT_W-1:0]    req_bit_count  = '0;

   // response side
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic                  rsp_ir_on;
   logic                  rsp_busy_res;
   logic                  rsp_load_rejected;
   logic                  rsp_frame_done;

   // csr port
   logic                  csr_psel       = 1'b0;
   logic                  csr_penable    = 1'b0;
   logic                  csr_pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr      = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata     = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // idling percentages, changed between modes
   int                    sender_idle_pct = 0;
   int                    rsp_stall_pct   = 0;

   int                    quiet_cycles = 0;
   int                    mismatch_count;
   int                    results_pending;
   logic                  frame_active;

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   ir_pulse_width_frame_sender u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_frame_data    (req_frame_data),
      .req_bit_count     (req_bit_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ir_on         (rsp_ir_on),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_load_rejected (rsp_load_rejected),
      .rsp_frame_done    (rsp_frame_done),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   ir_pulse_width_frame_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_frame_data    (req_frame_data),
      .req_bit_count     (req_bit_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ir_on         (rsp_ir_on),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_load_rejected (rsp_load_rejected),
      .rsp_frame_done    (rsp_frame_done),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_pready        (csr_pready),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .mismatch_count    (mismatch_count),
      .results_pending   (results_pending),
      .frame_active      (frame_active)
   );

   // receiver backpressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // give up once nothing has moved on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // returns at a falling edge once the sender is done idling
   task automatic wait_sender_slot();
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   // called at a falling edge; returns at the edge that takes the word
   task automatic push_word(input op_type op, input logic [DATA_W-1:0] data,
                            input logic [COUNT_W-1:0] count);
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_frame_data <= data;
      req_bit_count  <= count;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_word(input op_type op, input logic [DATA_W-1:0] data,
                            input logic [COUNT_W-1:0] count);
      wait_sender_slot();
      push_word(op, data, count);
   endtask

   // mostly ticks; loads are frequent while idle and rare mid-frame, so
   // most frames run to the end and a few loads get rejected
   task automatic send_random_word();
      op_type             op;
      logic [DATA_W-1:0]  data;
      logic [COUNT_W-1:0] count;
      int                 load_pct;
      wait_sender_slot();
      load_pct = frame_active ? 4 : 35;
      op       = ($urandom_range(99) < load_pct) ? OP_LOAD : OP_TICK;
      case ($urandom_range(9))
         0:       data = '0;
         1:       data = '1;
         default: data = $urandom();
      endcase
      case ($urandom_range(19))
         0, 1:    count = COUNT_W'($urandom_range(0, 63));
         2:       count = COUNT_W'(32);
         default: count = COUNT_W'($urandom_range(1, 8));
      endcase
      push_word(op, data, count);
   endtask

   // tick until the predicted frame has finished
   task automatic drain_frame();
      bit more;
      more = 1'b1;
      while (more) begin
         wait_sender_slot();
         more = frame_active;
         if (more)
            push_word(OP_TICK, $urandom(), COUNT_W'($urandom()));
         else
            req_valid <= 1'b0;
      end
   endtask

   // stop sending and let every outstanding response come back
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (results_pending == 0);
   endtask

   // two-phase csr write; upper data bits are noise the block must drop
   task automatic write_reg(input reg_index_type idx, input logic [DUR_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'($urandom()), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic write_timing(input logic [DUR_W-1:0] start_len,
                               input logic [DUR_W-1:0] one_len,
                               input logic [DUR_W-1:0] zero_len,
                               input logic [DUR_W-1:0] space_len);
      write_reg(REG_START_MARK, start_len);
      write_reg(REG_ONE_MARK, one_len);
      write_reg(REG_ZERO_MARK, zero_len);
      write_reg(REG_SPACE, space_len);
   endtask

   // short durations keep frames to tens of ticks; now and then a zero
   // register (one tick) or a somewhat longer phase
   function automatic logic [DUR_W-1:0] pick_len();
      case ($urandom_range(9))
         0:       return '0;
         1:       return DUR_W'($urandom_range(5, 12));
         default: return DUR_W'($urandom_range(1, 4));
      endcase
   endfunction

   initial begin
      // synchronous reset, released once
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // first mode: sender idles a third of the time, receiver two thirds
      sender_idle_pct = 35;
      rsp_stall_pct   = 65;

      // directed opening; the zero-mark register at zero gives one-tick marks
      write_timing(16'd2, 16'd3, 16'd0, 16'd1);
      send_word(OP_TICK, '1, '1);                 // tick while idle: all flags low
      send_word(OP_LOAD, '1, 6'd0);               // no data bits: start mark and space
      send_word(OP_LOAD, '0, 6'd5);               // load while busy is rejected
      drain_frame();
      send_word(OP_LOAD, 32'h0000_0001, 6'd1);    // single long mark
      send_word(OP_LOAD, '1, 6'd32);              // rejected again, full count
      drain_frame();
      send_word(OP_LOAD, 32'hFFFF_FFFE, 6'd1);    // single short mark
      drain_frame();
      send_word(OP_TICK, '0, '0);
      send_word(OP_LOAD, 32'h8000_0001, 6'd40);   // count above the frame limit
      // that frame is finished by the random traffic below

      // random traffic under three idling modes, new durations per segment
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               sender_idle_pct = 35;
               rsp_stall_pct   = 65;
            end
            1: begin
               sender_idle_pct = 65;
               rsp_stall_pct   = 35;
            end
            default: begin
               sender_idle_pct = 0;
               rsp_stall_pct   = 0;
            end
         endcase
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            quiesce();
            write_timing(pick_len(), pick_len(), pick_len(), pick_len());
            repeat (SEGMENT_WORDS) send_random_word();
         end
      end

      // every duration at its maximum: load a frame and run a few ticks of
      // its start mark, plus a rejected load on top
      drain_frame();
      quiesce();
      write_timing('1, '1, '1, '1);
      send_word(OP_LOAD, 32'h0000_0002, 6'd2);
      repeat (MAX_LEN_TICKS) send_word(OP_TICK, $urandom(), COUNT_W'($urandom()));
      send_word(OP_LOAD, '1, 6'd8);

      // wind down and give the verdict
      quiesce();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0 && results_pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
